// File: design/rkt_pkg.sv
// ----------------------------------------------------------------------------
// rkt_pkg
// Shared types and constants for the radius keypoint thinning block.
// ----------------------------------------------------------------------------
`default_nettype none

package rkt_pkg;

	// store geometry
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths
	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 48;
	localparam int SLOT_W   = 10;

	// distance datapath widths
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int SUM_W    = SQ_W + 2;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pose_t;

	// status from the distance pipeline to the controller
	typedef struct packed {
		logic busy;
		logic hit;
	} dist_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} rkt_state_t;

endpackage

`default_nettype wire

// File: design/rkt_pose_if.sv
// ----------------------------------------------------------------------------
// rkt_pose_if
// Pose request channel: valid/ready with three signed coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkt_pose_if;
	import rkt_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

// File: design/rkt_result_if.sv
// ----------------------------------------------------------------------------
// rkt_result_if
// Result channel: valid/ready with keep flag, slot index and full flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkt_result_if;
	import rkt_pkg::*;

	logic              valid;
	logic              ready;
	logic              kept;
	logic [SLOT_W-1:0] slot_index;
	logic              store_full;

	modport source (output valid, output kept, output slot_index, output store_full,
		input ready);
	modport sink   (input valid, input kept, input slot_index, input store_full,
		output ready);
endinterface

`default_nettype wire

// File: design/rkt_cfg_if.sv
// ----------------------------------------------------------------------------
// rkt_cfg_if
// Configuration write channel carrying the squared acceptance radius.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkt_cfg_if;
	import rkt_pkg::*;

	logic                valid;
	logic                ready;
	logic [RADIUS_W-1:0] radius_sq;

	modport source (output valid, output radius_sq, input ready);
	modport sink   (input valid, input radius_sq, output ready);
endinterface

`default_nettype wire

// File: design/rkt_pose_mem.sv
// ----------------------------------------------------------------------------
// rkt_pose_mem
// Pose store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rkt_pose_mem (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [rkt_pkg::IDX_W-1:0] wr_addr,
	input  wire rkt_pkg::pose_t      wr_data,
	input  wire logic                rd_en,
	input  wire logic [rkt_pkg::IDX_W-1:0] rd_addr,
	output rkt_pkg::pose_t           rd_data
);
	import rkt_pkg::*;

	pose_t mem [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

`default_nettype wire

// File: design/rkt_dist_pipe.sv
// ----------------------------------------------------------------------------
// rkt_dist_pipe
// Three-stage squared distance pipeline: abs difference, squares, sum and
// compare against the radius.
// ----------------------------------------------------------------------------
`default_nettype none

module rkt_dist_pipe (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_vld,
	input  wire rkt_pkg::pose_t         stored,
	input  wire rkt_pkg::pose_t         pose,
	input  wire logic [rkt_pkg::RADIUS_W-1:0] radius_sq,
	output rkt_pkg::dist_stat_t         stat
);
	import rkt_pkg::*;

	logic vld_s2, vld_s3, vld_s4;
	logic le_s4;

	logic [DIFF_W-1:0] ax_s2, ay_s2, az_s2;
	logic [SQ_W-1:0]   sx_s3, sy_s3, sz_s3;

	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic [SUM_W-1:0]         sum;

	// signed differences and magnitudes
	always_comb begin
		dx = DIFF_W'($signed(pose.x)) - DIFF_W'($signed(stored.x));
		dy = DIFF_W'($signed(pose.y)) - DIFF_W'($signed(stored.y));
		dz = DIFF_W'($signed(pose.z)) - DIFF_W'($signed(stored.z));
	end

	always_ff @(posedge clk) begin
		ax_s2 <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		ay_s2 <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		az_s2 <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
	end

	// squares, one multiplier per axis
	always_ff @(posedge clk) begin
		sx_s3 <= SQ_W'(ax_s2 * ax_s2);
		sy_s3 <= SQ_W'(ay_s2 * ay_s2);
		sz_s3 <= SQ_W'(az_s2 * az_s2);
	end

	// sum and boundary-inclusive compare
	assign sum = SUM_W'(sx_s3) + SUM_W'(sy_s3) + SUM_W'(sz_s3);

	always_ff @(posedge clk) begin
		le_s4 <= (sum <= SUM_W'(radius_sq));
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign stat.busy = in_vld | vld_s2 | vld_s3 | vld_s4;
	assign stat.hit  = vld_s4 & le_s4;
endmodule

`default_nettype wire

// File: design/radius_keypoint_thinning.sv
// ----------------------------------------------------------------------------
// radius_keypoint_thinning
// Distance-based keyframe selection over a store of up to 1024 poses.
// ----------------------------------------------------------------------------
// Usage:
//   pose   : request channel, one 3-D pose (signed 1/256 m) per request.
//   result : one response per pose: kept, slot_index, store_full.
//   cfg    : writes radius_sq; write only while no pose is in flight.
// A pose is scanned against every stored pose, one memory read per cycle
// through a read/difference/square/compare pipeline. The single read port
// of the pose store sets the rate: one stored pose per cycle, one pose in
// work at a time.
// A kept pose is written back to the store at the end of its scan.
// The response waits in an output register; the next pose is taken while
// it waits, but its own response is held until the receiver takes the
// previous one.
// Reset empties the store (count to zero) and sets radius_sq to 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_keypoint_thinning (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rkt_pose_if.sink     pose,
	rkt_result_if.source result,
	rkt_cfg_if.sink      cfg
);
	import rkt_pkg::*;

	rkt_state_t state_q, state_nx;

	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [RADIUS_W-1:0] radius_q;
	logic                near_q;
	pose_t               pose_q;
	logic                rd_vld_s1;

	logic                res_valid_q;
	logic                kept_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                full_q;

	logic       accept, rd_en, decide, last_rd, pipe_busy, store_is_full, keep_now;
	pose_t      rd_data, in_pose;
	dist_stat_t stat;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg.valid) begin
			radius_q <= cfg.radius_sq;
		end
	end

	assign in_pose.x = pose.pos_x;
	assign in_pose.y = pose.pos_y;
	assign in_pose.z = pose.pos_z;

	assign accept        = pose.valid & pose.ready;
	assign last_rd       = (idx_q == count_q - CNT_W'(1));
	assign pipe_busy     = rd_vld_s1 | stat.busy;
	assign store_is_full = (count_q == CNT_W'(CAPACITY));
	assign keep_now      = ~near_q & ~store_is_full;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pose.valid) begin
					state_nx = (count_q == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy && (!res_valid_q || result.ready)) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		pose.ready = 1'b0;
		rd_en      = 1'b0;
		decide     = 1'b0;
		case (state_q)
			ST_IDLE:  pose.ready = 1'b1;
			ST_SCAN:  rd_en = 1'b1;
			ST_DRAIN: decide = !pipe_busy && (!res_valid_q || result.ready);
			default: begin
				pose.ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			count_q   <= '0;
			near_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				idx_q  <= '0;
				near_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (stat.hit) begin
					near_q <= 1'b1;
				end
			end
			if (decide && keep_now) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// captured pose
	always_ff @(posedge clk) begin
		if (accept) begin
			pose_q <= in_pose;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (decide) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			kept_q <= keep_now;
			slot_q <= keep_now ? count_q[SLOT_W-1:0] : '0;
			full_q <= ~near_q & store_is_full;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.kept       = kept_q;
	assign result.slot_index = slot_q;
	assign result.store_full = full_q;

	// pose store
	rkt_pose_mem u_mem (
		.clk     (clk),
		.wr_en   (decide & keep_now),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (pose_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// distance pipeline
	rkt_dist_pipe u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rd_vld_s1),
		.stored    (rd_data),
		.pose      (pose_q),
		.radius_sq (radius_q),
		.stat      (stat)
	);
endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radius_keypoint_thinning. Poses go in through a
// queued driver and a scoreboard of keep/drop verdicts follows the pose
// store; each response is checked against the oldest verdict. Covers the
// radius boundary, the register extremes and back-pressure.
// ----------------------------------------------------------------------------

module tb;
	import rkt_pkg::*;

	localparam int C_MAX        = 8388607;
	localparam int C_MIN        = -8388608;
	localparam int HOLD_CYCLES  = 3000;
	localparam int STALL_LIMIT  = 20000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic              kept;
		logic [SLOT_W-1:0] slot_index;
		logic              store_full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	rkt_pose_if   pose_ch ();
	rkt_result_if result_ch ();
	rkt_cfg_if    cfg_ch ();

	radius_keypoint_thinning u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// pending requests and expected verdicts
	pose_t                pose_backlog[$];
	logic [RADIUS_W-1:0]  radius_backlog[$];
	verdict_t             keep_verdicts[$];

	// mirror of the pose store and the radius register
	coord_t              kept_x [CAPACITY];
	coord_t              kept_y [CAPACITY];
	coord_t              kept_z [CAPACITY];
	int                  kept_cnt = 0;
	logic [RADIUS_W-1:0] radius_model = RADIUS_RESET;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_start = 1'b0;
	int          hold_left = 0;
	int          error_cnt = 0;
	int unsigned stall_cycles = 0;

	// random pose shaping
	int cl_center [3];
	int cl_span = 0;
	int probe_root = 0;

	// keep/drop decision for one pose; updates the store mirror
	function automatic verdict_t predict_keep(pose_t p);
		verdict_t v;
		bit       near;
		longint   dx, dy, dz, d2;
		int       i;
		v = '0;
		near = 1'b0;
		for (i = 0; i < kept_cnt && !near; i++) begin
			dx = longint'($signed(p.x)) - longint'($signed(kept_x[i]));
			dy = longint'($signed(p.y)) - longint'($signed(kept_y[i]));
			dz = longint'($signed(p.z)) - longint'($signed(kept_z[i]));
			d2 = dx * dx + dy * dy + dz * dz;
			if (d2 <= longint'({16'd0, radius_model}))
				near = 1'b1;
		end
		if (near)
			return v;
		if (kept_cnt >= CAPACITY) begin
			v.store_full = 1'b1;
			return v;
		end
		kept_x[kept_cnt] = p.x;
		kept_y[kept_cnt] = p.y;
		kept_z[kept_cnt] = p.z;
		v.kept = 1'b1;
		v.slot_index = SLOT_W'(kept_cnt);
		kept_cnt++;
		return v;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > C_MAX)
			return coord_t'(C_MAX);
		if (v < C_MIN)
			return coord_t'(C_MIN);
		return coord_t'(v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 25;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// move one axis of a stored pose by r toward zero
	function automatic pose_t shifted_pose(int idx, int axis, int r);
		coord_t c [3];
		longint base;
		c[0] = kept_x[idx];
		c[1] = kept_y[idx];
		c[2] = kept_z[idx];
		base = longint'($signed(c[axis]));
		c[axis] = clamp_coord(base >= 0 ? base - r : base + r);
		return '{x: c[0], y: c[1], z: c[2]};
	endfunction

	// mix: cluster around a center, probes at the radius of a stored pose, noise
	function automatic pose_t draw_pose();
		pose_t       p;
		int unsigned roll;
		coord_t      c [3];
		int          k;
		roll = $urandom_range(0, 99);
		if (roll < 20 || cl_span == 0) begin
			p.x = coord_t'($urandom());
			p.y = coord_t'($urandom());
			p.z = coord_t'($urandom());
		end else if (roll < 40 && kept_cnt != 0) begin
			p = shifted_pose($urandom_range(0, kept_cnt - 1), $urandom_range(0, 2),
				probe_root + int'($urandom_range(0, 2)) - 1);
		end else begin
			for (k = 0; k < 3; k++)
				c[k] = clamp_coord(longint'(cl_center[k]) +
					longint'($urandom_range(0, 2 * cl_span)) - cl_span);
			p = '{x: c[0], y: c[1], z: c[2]};
		end
		return p;
	endfunction

	task automatic offer_pose(int x, int y, int z);
		pose_t p;
		p = '{x: coord_t'(x), y: coord_t'(y), z: coord_t'(z)};
		pose_backlog = {pose_backlog, p};
	endtask

	task automatic offer_random(int n);
		pose_t p;
		repeat (n) begin
			p = draw_pose();
			pose_backlog = {pose_backlog, p};
		end
	endtask

	// checked at the falling edge, after every request of the rising edge settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pose_backlog.size() != 0 || pose_ch.valid || keep_verdicts.size() != 0);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] value);
		radius_backlog = {radius_backlog, value};
		do
			@(negedge clk);
		while (radius_backlog.size() != 0 || cfg_ch.valid);
	endtask

	task automatic set_cluster(longint unsigned radius, int span);
		int k;
		for (k = 0; k < 3; k++)
			cl_center[k] = int'($urandom_range(0, 1 << 23)) - (1 << 22);
		cl_span = span;
		probe_root = int'(root_floor(radius));
	endtask

	task automatic log_error(string what, verdict_t want, verdict_t got);
		error_cnt++;
		if (error_cnt <= REPORT_LIMIT)
			$display("ERROR %s: expected kept=%0d slot=%0d full=%0d, got kept=%0d slot=%0d full=%0d",
				what, want.kept, want.slot_index, want.store_full,
				got.kept, got.slot_index, got.store_full);
	endtask

	// pose driver; the verdict is worked out when the request is taken
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			if (pose_ch.valid && pose_ch.ready) begin
				v = predict_keep('{x: pose_ch.pos_x, y: pose_ch.pos_y, z: pose_ch.pos_z});
				keep_verdicts = {keep_verdicts, v};
			end
			if (!pose_ch.valid || pose_ch.ready) begin
				if (pose_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					pose_ch.valid <= 1'b1;
					pose_ch.pos_x <= pose_backlog[0].x;
					pose_ch.pos_y <= pose_backlog[0].y;
					pose_ch.pos_z <= pose_backlog[0].z;
					void'(pose_backlog.pop_front());
				end else begin
					pose_ch.valid <= 1'b0;
				end
			end
		end
	end

	// radius write driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				radius_model = cfg_ch.radius_sq;
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (radius_backlog.size() != 0) begin
					cfg_ch.valid <= 1'b1;
					cfg_ch.radius_sq <= radius_backlog.pop_front();
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		verdict_t got;
		if (arst_n) begin
			result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
			if (result_ch.valid && result_ch.ready) begin
				got = '{kept: result_ch.kept, slot_index: result_ch.slot_index,
					store_full: result_ch.store_full};
				if (keep_verdicts.size() == 0)
					log_error("unexpected result", '0, got);
				else if (got.kept !== keep_verdicts[0].kept ||
						got.slot_index !== keep_verdicts[0].slot_index ||
						got.store_full !== keep_verdicts[0].store_full)
					log_error("result mismatch", keep_verdicts.pop_front(), got);
				else
					void'(keep_verdicts.pop_front());
			end
		end
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((pose_ch.valid && pose_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		longint unsigned rr;
		arst_n = 1'b0;
		pose_ch.valid = 1'b0;
		pose_ch.pos_x = '0;
		pose_ch.pos_y = '0;
		pose_ch.pos_z = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.radius_sq = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset radius of 1 m: first pose, boundary on each axis, extremes
		offer_pose(0, 0, 0);
		offer_pose(256, 0, 0);
		offer_pose(0, -256, 0);
		offer_pose(0, 0, 256);
		offer_pose(257, 0, 0);
		offer_pose(0, 255, 1);
		offer_pose(C_MAX, C_MAX, C_MAX);
		offer_pose(C_MIN, C_MIN, C_MIN);
		offer_pose(C_MIN, C_MAX, C_MIN);
		offer_pose(C_MAX, C_MIN, 0);
		offer_pose(C_MAX, C_MAX, C_MAX - 256);
		offer_pose(-1, -1, -1);
		wait_idle();

		// zero radius: only exact duplicates are dropped
		write_radius('0);
		offer_pose(0, 0, 0);
		offer_pose(1, 0, 0);
		offer_pose(C_MIN, C_MIN, C_MIN);
		offer_pose(C_MAX, C_MAX, C_MAX - 1);
		wait_idle();

		// widest radius
		write_radius('1);
		offer_pose(0, 0, -1);
		offer_pose(C_MAX, C_MIN, C_MAX);
		offer_pose(0, C_MAX, C_MIN);
		offer_pose(C_MIN, 0, C_MAX);
		wait_idle();

		// random, slow receiver, with a pause until all results are back
		send_idle_pct = 7;
		recv_idle_pct = 80;
		rr = 512;
		write_radius(RADIUS_W'(rr * rr));
		set_cluster(rr * rr, 2048);
		offer_random(100);
		wait_idle();
		offer_random(100);
		wait_idle();

		// random, slow sender, random radius
		send_idle_pct = 80;
		recv_idle_pct = 7;
		rr = $urandom_range(2, 60000);
		write_radius(RADIUS_W'(rr * rr + $urandom_range(0, 1)));
		set_cluster(rr * rr, int'(rr) * 3);
		offer_random(180);
		wait_idle();

		// random, no idling; receiver holds off long enough to stall the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rr = $urandom_range(1, 40);
		write_radius(RADIUS_W'(rr * rr));
		set_cluster(rr * rr, int'(rr) * 8);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		offer_random(200);
		wait_idle();

		// drain margin for any stray response
		repeat (32) @(posedge clk);
		if (keep_verdicts.size() != 0)
			log_error("missing result", keep_verdicts[0], '0);
		if (error_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
design/rkt_pkg.sv
design/rkt_pose_if.sv
design/rkt_result_if.sv
design/rkt_cfg_if.sv
design/rkt_pose_mem.sv
design/rkt_dist_pipe.sv
design/radius_keypoint_thinning.sv
dv/tb.sv
